[src/uvs_pkg.sv]
// shared types, constants and the cordic angle table of the uv sphere vertex generator
package uvs_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [33:0] INV_GAIN = 34'sd652032874;
    localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

    // register indexes of the configuration channel
    localparam logic CFG_X_SEG = 1'b0;
    localparam logic CFG_Y_SEG = 1'b1;

    typedef struct packed {
        logic [8:0]  rc;
        logic [8:0]  cc;
        logic [8:0]  xs;
        logic [8:0]  ys;
        logic        in_range;
        logic        cell_valid;
        logic [16:0] idx_below;
        logic [16:0] idx_here;
        logic [16:0] idx_right;
        logic [16:0] idx_diag;
    } vtx_cmd_t;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pos_z;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic        in_range;
        logic        cell_valid;
        logic [16:0] idx_below;
        logic [16:0] idx_here;
        logic [16:0] idx_right;
        logic [16:0] idx_diag;
    } vtx_res_t;

    // atan(2^-i) in q2.30 radians, truncated
    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] v;
        case (i)
            0:       v = 34'sd843314856;
            1:       v = 34'sd497837829;
            2:       v = 34'sd263043836;
            3:       v = 34'sd133525158;
            4:       v = 34'sd67021686;
            5:       v = 34'sd33543515;
            6:       v = 34'sd16775850;
            7:       v = 34'sd8388437;
            8:       v = 34'sd4194282;
            9:       v = 34'sd2097149;
            10:      v = 34'sd1048575;
            11:      v = 34'sd524287;
            12:      v = 34'sd262143;
            13:      v = 34'sd131071;
            14:      v = 34'sd65535;
            15:      v = 34'sd32767;
            16:      v = 34'sd16383;
            17:      v = 34'sd8191;
            18:      v = 34'sd4095;
            19:      v = 34'sd2047;
            20:      v = 34'sd1023;
            21:      v = 34'sd511;
            22:      v = 34'sd255;
            23:      v = 34'sd127;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

[src/uv_sphere_vertex_generator.sv]
// top level of the uv sphere vertex generator
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------
//  grid in   | push / full            | row, col
//  vertex out| pop / empty            | pos_x/y/z, tex_u/v, flags, four indices
//  config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one transaction in and one out per cycle sustained while the consumer keeps
// popping; the back end holds the 17 divider stages, the angle fold and seed,
// the cordic stages, the quadrant and product stages and the rounding stage
// reset: segment counts go to 32 and 16, both queues empty, pipeline drained
// a stalled output stops the back end only; the command queue keeps
// taking transactions until it fills
module uv_sphere_vertex_generator
    import uvs_pkg::*;
#(
    parameter int MAX_SEGMENTS = 256,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data,
    // grid point in
    input  logic        push,
    output logic        full,
    input  logic [8:0]  row,
    input  logic [8:0]  col,
    // vertex out
    output logic        empty,
    input  logic        pop,
    output logic [15:0] pos_x,
    output logic [15:0] pos_y,
    output logic [15:0] pos_z,
    output logic [16:0] tex_u,
    output logic [16:0] tex_v,
    output logic        in_range,
    output logic        cell_valid,
    output logic [16:0] index_below,
    output logic [16:0] index_here,
    output logic [16:0] index_right,
    output logic [16:0] index_diagonal
);

    localparam int QDEPTH = 4;

    logic [8:0] x_seg_reg, y_seg_reg;
    vtx_cmd_t   front_cmd, mid_cmd;
    vtx_res_t   back_res, out_res;
    logic       mid_empty, mid_pop;
    logic       out_full, back_push;

    // registers are always writable; the user must write them only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_seg_reg <= 9'd32;
            y_seg_reg <= 9'd16;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_X_SEG: x_seg_reg <= cfg_data;
                default:   y_seg_reg <= cfg_data;
            endcase
        end
    end

    // classify the point and work out its cell indices
    uvs_front #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_front (
        .x_seg(x_seg_reg),
        .y_seg(y_seg_reg),
        .row  (row),
        .col  (col),
        .cmd  (front_cmd)
    );

    // decouples the front end from back end stalls
    uvs_fifo #(
        .WIDTH($bits(vtx_cmd_t)),
        .DEPTH(QDEPTH)
    ) u_cmd_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .wdata(front_cmd),
        .full (full),
        .pop  (mid_pop),
        .rdata(mid_cmd),
        .empty(mid_empty)
    );

    // texture division, trig and products
    uvs_back #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_empty(mid_empty),
        .cmd      (mid_cmd),
        .cmd_pop  (mid_pop),
        .res_full (out_full),
        .res_push (back_push),
        .res      (back_res)
    );

    // finished vertices wait here for the consumer
    uvs_fifo #(
        .WIDTH($bits(vtx_res_t)),
        .DEPTH(QDEPTH)
    ) u_res_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (back_push),
        .wdata(back_res),
        .full (out_full),
        .pop  (pop),
        .rdata(out_res),
        .empty(empty)
    );

    assign pos_x          = out_res.pos_x;
    assign pos_y          = out_res.pos_y;
    assign pos_z          = out_res.pos_z;
    assign tex_u          = out_res.tex_u;
    assign tex_v          = out_res.tex_v;
    assign in_range       = out_res.in_range;
    assign cell_valid     = out_res.cell_valid;
    assign index_below    = out_res.idx_below;
    assign index_here     = out_res.idx_here;
    assign index_right    = out_res.idx_right;
    assign index_diagonal = out_res.idx_diag;

`ifndef NO_ASSERTIONS
    // back end never pushes into a full result queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        back_push |-> !out_full)
        else $error("result pushed into full queue");

    // an accepted transaction is waiting in the command queue next cycle
    a_cmd_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> !mid_empty)
        else $error("accepted transaction lost");

    // a cell only exists for an in-range point
    a_cell_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && cell_valid) |-> in_range)
        else $error("cell flagged outside grid");

    // texture coordinates never exceed one
    a_tex_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (tex_u <= 17'd65536 && tex_v <= 17'd65536))
        else $error("texture coordinate above one");
`endif

endmodule

[src/uvs_fifo.sv]
// small generic queue with registered storage
module uvs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

[src/uvs_front.sv]
// front end: segment clamping, grid flags and flattened cell indices
module uvs_front
    import uvs_pkg::*;
#(
    parameter int MAX_SEGMENTS = 256
) (
    input  logic [8:0] x_seg,
    input  logic [8:0] y_seg,
    input  logic [8:0] row,
    input  logic [8:0] col,
    output vtx_cmd_t   cmd
);

    function automatic logic [8:0] eff_seg(input logic [8:0] raw);
        logic [8:0] v;
        if (raw == '0)
            v = 9'd1;
        else if ({2'b00, raw} > 11'(MAX_SEGMENTS))
            v = 9'(MAX_SEGMENTS);
        else
            v = raw;
        return v;
    endfunction

    logic [8:0]  xs, ys;
    logic [9:0]  stride;
    logic [19:0] here_w;
    logic        has_quad;

    always_comb
    begin
        xs       = eff_seg(x_seg);
        ys       = eff_seg(y_seg);
        stride   = {1'b0, xs} + 10'd1;
        here_w   = 20'(row) * 20'(stride) + 20'(col);
        has_quad = (row < ys) && (col < xs);

        cmd            = '0;
        cmd.xs         = xs;
        cmd.ys         = ys;
        cmd.rc         = (row > ys) ? ys : row;
        cmd.cc         = (col > xs) ? xs : col;
        cmd.in_range   = (row <= ys) && (col <= xs);
        cmd.cell_valid = has_quad;
        if (has_quad)
        begin
            cmd.idx_here  = here_w[16:0];
            cmd.idx_right = 17'(here_w + 20'd1);
            cmd.idx_below = 17'(here_w + 20'(stride));
            cmd.idx_diag  = 17'(here_w + 20'(stride) + 20'd1);
        end
    end

endmodule

[src/uvs_back.sv]
// back end: pipelined dividers, angle fold, two cordic lanes and products
module uvs_back
    import uvs_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_empty,
    input  vtx_cmd_t cmd,
    output logic     cmd_pop,
    input  logic     res_full,
    output logic     res_push,
    output vtx_res_t res
);

    localparam int CS    = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int A_IDX = 17;
    localparam int B_IDX = 18;
    localparam int C0    = 19;
    localparam int Q_IDX = C0 + CS;
    localparam int P_IDX = Q_IDX + 1;
    localparam int R_IDX = P_IDX + 1;
    localparam int NST   = R_IDX + 1;

    typedef struct packed {
        vtx_cmd_t    cmd;
        logic [16:0] tu;
        logic [16:0] tv;
        logic [8:0]  ru;
        logic [8:0]  rv;
        logic [1:0]  qt;
        logic [1:0]  qp;
        logic        neg_t;
        logic        neg_p;
        logic [47:0] mt;
        logic [47:0] mp;
        logic [33:0] xt;
        logic [33:0] yt;
        logic [33:0] zt;
        logic [33:0] xp;
        logic [33:0] yp;
        logic [33:0] zp;
        logic [31:0] cos_th;
        logic [31:0] sin_th;
        logic [31:0] cos_ph;
        logic [31:0] sin_ph;
        logic [63:0] pxs;
        logic [63:0] pzs;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] pz;
    } stage_t;

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [9:0] div_step(input logic [8:0] rem, input logic [8:0] d);
        logic [9:0] t;
        logic [9:0] r;
        t = {rem, 1'b0};
        if (t >= {1'b0, d})
            r = {1'b1, 9'(t - {1'b0, d})};
        else
            r = {1'b0, t[8:0]};
        return r;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [63:0] v);
        logic [15:0] r;
        if (v > 64'sd32767)
            r = 16'h7fff;
        else if (v < -64'sd32768)
            r = 16'h8000;
        else
            r = v[15:0];
        return r;
    endfunction

    stage_t stg_reg  [NST];
    stage_t stg_next [NST];
    logic   vld_reg  [NST];
    logic   en;

    assign en       = !(vld_reg[NST-1] && res_full);
    assign cmd_pop  = en && !cmd_empty;
    assign res_push = en && vld_reg[NST-1];

    for (genvar k = 0; k < NST; k++)
    begin : g_stage
        stage_t nxt;
        if (k == 0)
        begin : g_div_first
            always_comb
            begin
                nxt     = '0;
                nxt.cmd = cmd;
                if (cmd.cc >= cmd.xs)
                begin
                    nxt.tu[16] = 1'b1;
                    nxt.ru     = cmd.cc - cmd.xs;
                end
                else
                    nxt.ru = cmd.cc;
                if (cmd.rc >= cmd.ys)
                begin
                    nxt.tv[16] = 1'b1;
                    nxt.rv     = cmd.rc - cmd.ys;
                end
                else
                    nxt.rv = cmd.rc;
            end
        end
        else if (k < A_IDX)
        begin : g_div
            always_comb
            begin
                logic [9:0] su, sv;
                nxt = stg_reg[k-1];
                su  = div_step(nxt.ru, nxt.cmd.xs);
                sv  = div_step(nxt.rv, nxt.cmd.ys);
                nxt.tu[16-k] = su[9];
                nxt.ru       = su[8:0];
                nxt.tv[16-k] = sv[9];
                nxt.rv       = sv[8:0];
            end
        end
        else if (k == A_IDX)
        begin : g_fold
            // quadrant plus residue in [-1/8, 1/8) turn, residue scaled by 2*pi
            always_comb
            begin
                logic [16:0]        at, ap;
                logic signed [16:0] rt, rp;
                logic [16:0]        mag_t, mag_p;
                nxt   = stg_reg[k-1];
                at    = {nxt.tu[15:0], 1'b0} + 17'd16384;
                ap    = nxt.tv + 17'd16384;
                rt    = $signed({2'b00, at[14:0]}) - 17'sd16384;
                rp    = $signed({2'b00, ap[14:0]}) - 17'sd16384;
                mag_t = rt[16] ? 17'(-rt) : 17'(rt);
                mag_p = rp[16] ? 17'(-rp) : 17'(rp);
                nxt.qt    = at[16:15];
                nxt.qp    = ap[16:15];
                nxt.neg_t = rt[16];
                nxt.neg_p = rp[16];
                nxt.mt    = 48'(mag_t[14:0]) * 48'(TWO_PI_Q30);
                nxt.mp    = 48'(mag_p[14:0]) * 48'(TWO_PI_Q30);
            end
        end
        else if (k == B_IDX)
        begin : g_seed
            always_comb
            begin
                logic [30:0] rad_t, rad_p;
                nxt   = stg_reg[k-1];
                rad_t = 31'((nxt.mt + 48'd65536) >> 17);
                rad_p = 31'((nxt.mp + 48'd65536) >> 17);
                nxt.zt = nxt.neg_t ? 34'(-$signed({3'b000, rad_t})) : {3'b000, rad_t};
                nxt.zp = nxt.neg_p ? 34'(-$signed({3'b000, rad_p})) : {3'b000, rad_p};
                nxt.xt = INV_GAIN;
                nxt.xp = INV_GAIN;
                nxt.yt = '0;
                nxt.yp = '0;
            end
        end
        else if (k < Q_IDX)
        begin : g_rot
            localparam int I = k - C0;
            always_comb
            begin
                logic signed [33:0] dxt, dyt, dxp, dyp;
                nxt = stg_reg[k-1];
                dxt = $signed(nxt.yt) >>> I;
                dyt = $signed(nxt.xt) >>> I;
                dxp = $signed(nxt.yp) >>> I;
                dyp = $signed(nxt.xp) >>> I;
                if (!nxt.zt[33])
                begin
                    nxt.xt = nxt.xt - dxt;
                    nxt.yt = nxt.yt + dyt;
                    nxt.zt = nxt.zt - atan_q30(I);
                end
                else
                begin
                    nxt.xt = nxt.xt + dxt;
                    nxt.yt = nxt.yt - dyt;
                    nxt.zt = nxt.zt + atan_q30(I);
                end
                if (!nxt.zp[33])
                begin
                    nxt.xp = nxt.xp - dxp;
                    nxt.yp = nxt.yp + dyp;
                    nxt.zp = nxt.zp - atan_q30(I);
                end
                else
                begin
                    nxt.xp = nxt.xp + dxp;
                    nxt.yp = nxt.yp - dyp;
                    nxt.zp = nxt.zp + atan_q30(I);
                end
            end
        end
        else if (k == Q_IDX)
        begin : g_quad
            always_comb
            begin
                nxt = stg_reg[k-1];
                case (nxt.qt)
                    2'd0:
                    begin
                        nxt.cos_th = nxt.xt[31:0];
                        nxt.sin_th = nxt.yt[31:0];
                    end
                    2'd1:
                    begin
                        nxt.cos_th = 32'(-$signed(nxt.yt));
                        nxt.sin_th = nxt.xt[31:0];
                    end
                    2'd2:
                    begin
                        nxt.cos_th = 32'(-$signed(nxt.xt));
                        nxt.sin_th = 32'(-$signed(nxt.yt));
                    end
                    default:
                    begin
                        nxt.cos_th = nxt.yt[31:0];
                        nxt.sin_th = 32'(-$signed(nxt.xt));
                    end
                endcase
                case (nxt.qp)
                    2'd0:
                    begin
                        nxt.cos_ph = nxt.xp[31:0];
                        nxt.sin_ph = nxt.yp[31:0];
                    end
                    2'd1:
                    begin
                        nxt.cos_ph = 32'(-$signed(nxt.yp));
                        nxt.sin_ph = nxt.xp[31:0];
                    end
                    2'd2:
                    begin
                        nxt.cos_ph = 32'(-$signed(nxt.xp));
                        nxt.sin_ph = 32'(-$signed(nxt.yp));
                    end
                    default:
                    begin
                        nxt.cos_ph = nxt.yp[31:0];
                        nxt.sin_ph = 32'(-$signed(nxt.xp));
                    end
                endcase
            end
        end
        else if (k == P_IDX)
        begin : g_mul
            always_comb
            begin
                nxt     = stg_reg[k-1];
                nxt.pxs = 64'($signed(nxt.cos_th) * $signed(nxt.sin_ph));
                nxt.pzs = 64'($signed(nxt.sin_th) * $signed(nxt.sin_ph));
            end
        end
        else
        begin : g_round
            always_comb
            begin
                logic signed [63:0] ry;
                nxt    = stg_reg[k-1];
                ry     = 64'($signed(nxt.cos_ph)) + 64'sd16384;
                nxt.px = sat16(($signed(nxt.pxs) + 64'sh1000_0000_0000) >>> 45);
                nxt.pz = sat16(($signed(nxt.pzs) + 64'sh1000_0000_0000) >>> 45);
                nxt.py = sat16(ry >>> 15);
            end
        end
        assign stg_next[k] = nxt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= !cmd_empty;
            for (int i = 1; i < NST; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NST; i++)
                stg_reg[i] <= stg_next[i];
        end
    end

    always_comb
    begin
        res            = '0;
        res.pos_x      = stg_reg[NST-1].px;
        res.pos_y      = stg_reg[NST-1].py;
        res.pos_z      = stg_reg[NST-1].pz;
        res.tex_u      = stg_reg[NST-1].tu;
        res.tex_v      = stg_reg[NST-1].tv;
        res.in_range   = stg_reg[NST-1].cmd.in_range;
        res.cell_valid = stg_reg[NST-1].cmd.cell_valid;
        res.idx_below  = stg_reg[NST-1].cmd.idx_below;
        res.idx_here   = stg_reg[NST-1].cmd.idx_here;
        res.idx_right  = stg_reg[NST-1].cmd.idx_right;
        res.idx_diag   = stg_reg[NST-1].cmd.idx_diag;
    end

endmodule
